// File: hdl/bpc_pkg.sv
// Shared types and codes for the button press classifier.
// No dependencies; used by the interfaces, the step logic, the top level and the checker.
package bpc_pkg;

    // Configuration register indexes and widths
    localparam int unsigned CFG_W     = 14;
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd2;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 14'd20;
    localparam logic [CFG_W-1:0] SHORT_RST    = 14'd50;
    localparam logic [CFG_W-1:0] LONG_RST     = 14'd1500;

    localparam int unsigned ELAPSED_W = 10;
    localparam int unsigned CODE_W    = 3;

    // Button / event codes
    localparam logic [CODE_W-1:0] BTN_MODE   = 3'd0;
    localparam logic [CODE_W-1:0] BTN_LEFT   = 3'd1;
    localparam logic [CODE_W-1:0] BTN_RIGHT  = 3'd2;
    localparam logic [CODE_W-1:0] BTN_TOGGLE = 3'd3;
    localparam logic [CODE_W-1:0] BTN_HOLD   = 3'd4;
    localparam logic [CODE_W-1:0] BTN_NONE   = 3'd7;

    // Press tracking phases, one-hot
    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_DEBOUNCE = 5'b00010,
        PH_SHORT    = 5'b00100,
        PH_LONG     = 5'b01000,
        PH_RELEASE  = 5'b10000
    } t_phase;

    // Result word of one tick
    typedef struct packed {
        logic              event_valid;
        logic [CODE_W-1:0] event_code;
        logic              backlight_kick;
    } t_evt;

    // Input word held in the input register
    typedef struct packed {
        logic [ELAPSED_W-1:0] elapsed_ms;
        logic                 mode_level;
        logic                 left_level;
        logic                 right_level;
        logic                 toggle_level;
    } t_tick;

endpackage

// File: hdl/bpc_in_if.sv
// Tick input channel: valid/ready handshake with elapsed time and four button levels.
// Depends on bpc_pkg for field widths.
interface bpc_in_if
    import bpc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [ELAPSED_W-1:0] elapsed_ms;
    logic                 mode_level;
    logic                 left_level;
    logic                 right_level;
    logic                 toggle_level;

    modport source (output valid, elapsed_ms, mode_level, left_level, right_level,
                    toggle_level, input ready);
    modport sink   (input valid, elapsed_ms, mode_level, left_level, right_level,
                    toggle_level, output ready);
endinterface

// File: hdl/bpc_out_if.sv
// Event output channel: valid/ready handshake with the per-tick event word.
// Depends on bpc_pkg for field widths.
interface bpc_out_if
    import bpc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              event_valid;
    logic [CODE_W-1:0] event_code;
    logic              backlight_kick;

    modport source (output valid, event_valid, event_code, backlight_kick, input ready);
    modport sink   (input valid, event_valid, event_code, backlight_kick, output ready);
endinterface

// File: hdl/bpc_step.sv
// Combinational next-state and event logic for one tick of the press tracker.
// Depends on bpc_pkg; instantiated by button_press_classifier.
module bpc_step
    import bpc_pkg::*;
#(
    parameter int DELAY_BITS = 16
) (
    input  t_tick                  i_tick,
    input  t_phase                 i_phase,
    input  logic [CODE_W-1:0]      i_held,
    input  logic [DELAY_BITS-1:0]  i_delay,
    input  logic [CFG_W-1:0]       i_debounce_ms,
    input  logic [CFG_W-1:0]       i_short_ms,
    input  logic [CFG_W-1:0]       i_long_ms,
    output t_phase                 o_phase,
    output logic [CODE_W-1:0]      o_held,
    output logic [DELAY_BITS-1:0]  o_delay,
    output t_evt                   o_evt
);

    // Working width: room for config differences and delay minus elapsed
    localparam int CW = ((DELAY_BITS > CFG_W) ? DELAY_BITS : CFG_W) + 2;
    localparam logic signed [CW-1:0] DMAX =
        {{(CW-DELAY_BITS+1){1'b0}}, {(DELAY_BITS-1){1'b1}}};
    localparam logic signed [CW-1:0] DMIN = ~DMAX;

    function automatic logic [DELAY_BITS-1:0] sat(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        r = v;
        if (v > DMAX) r = DMAX;
        if (v < DMIN) r = DMIN;
        return r[DELAY_BITS-1:0];
    endfunction

    function automatic logic is_pos(input logic [DELAY_BITS-1:0] v);
        return !v[DELAY_BITS-1] && (|v);
    endfunction

    logic [CODE_W-1:0]     cur;
    logic                  pressed;
    logic                  same;
    logic [DELAY_BITS-1:0] d_sub;
    logic [DELAY_BITS-1:0] d_deb;
    logic [DELAY_BITS-1:0] d_short;
    logic [DELAY_BITS-1:0] d_long;

    // Priority encode: mode, left, right, toggle
    always_comb begin
        if (i_tick.mode_level)        cur = BTN_MODE;
        else if (i_tick.left_level)   cur = BTN_LEFT;
        else if (i_tick.right_level)  cur = BTN_RIGHT;
        else if (i_tick.toggle_level) cur = BTN_TOGGLE;
        else                          cur = BTN_NONE;
    end

    assign pressed = (cur != BTN_NONE);
    assign same    = (cur == i_held);

    // Saturated countdown candidates
    assign d_sub   = sat({{(CW-DELAY_BITS){i_delay[DELAY_BITS-1]}}, i_delay}
                         - CW'(i_tick.elapsed_ms));
    assign d_deb   = sat(CW'(i_debounce_ms));
    assign d_short = sat(CW'(i_short_ms));
    assign d_long  = sat(CW'(i_long_ms) - CW'(i_short_ms));

    always_comb begin
        o_phase = i_phase;
        o_held  = i_held;
        o_delay = i_delay;
        o_evt   = '0;
        case (i_phase)
            PH_DEBOUNCE: begin
                o_delay = d_sub;
                if (!is_pos(d_sub)) begin
                    // debounce done: enter short wait and test it in the same tick
                    o_evt.backlight_kick = pressed;
                    o_delay = d_short;
                    o_phase = PH_SHORT;
                    if (!same) begin
                        o_evt.event_valid = 1'b1;
                        o_evt.event_code  = i_held;
                        o_phase = PH_RELEASE;
                    end else if (!is_pos(d_short)) begin
                        if (i_held == BTN_MODE) begin
                            o_phase = PH_LONG;
                            o_delay = d_long;
                        end else begin
                            o_evt.event_valid = 1'b1;
                            o_evt.event_code  = i_held;
                            o_phase = PH_RELEASE;
                        end
                    end
                end
            end
            PH_SHORT: begin
                o_evt.backlight_kick = pressed;
                o_delay = d_sub;
                if (!same) begin
                    o_evt.event_valid = 1'b1;
                    o_evt.event_code  = i_held;
                    o_phase = PH_RELEASE;
                end else if (!is_pos(d_sub)) begin
                    if (i_held == BTN_MODE) begin
                        o_phase = PH_LONG;
                        o_delay = d_long;
                    end else begin
                        o_evt.event_valid = 1'b1;
                        o_evt.event_code  = i_held;
                        o_phase = PH_RELEASE;
                    end
                end
            end
            PH_LONG: begin
                o_evt.backlight_kick = pressed;
                o_delay = d_sub;
                if (!same) begin
                    // early release reports the button and falls through to idle
                    o_evt.event_valid = 1'b1;
                    o_evt.event_code  = i_held;
                    o_held  = BTN_NONE;
                    o_phase = PH_IDLE;
                end else if (!is_pos(d_sub)) begin
                    o_evt.event_valid = 1'b1;
                    o_evt.event_code  = BTN_HOLD;
                    o_phase = PH_RELEASE;
                end
            end
            PH_RELEASE: begin
                o_evt.backlight_kick = pressed;
                if (!same) begin
                    o_held  = BTN_NONE;
                    o_phase = PH_IDLE;
                end
            end
            default: begin
                // idle: latch the sampled button, start debounce on a press
                o_evt.backlight_kick = pressed;
                o_held  = cur;
                o_phase = PH_IDLE;
                if (pressed) begin
                    o_delay = d_deb;
                    o_phase = PH_DEBOUNCE;
                end
            end
        endcase
    end

endmodule

// File: hdl/button_press_classifier.sv
// Top level of the button press classifier: handshakes, config and state registers.
// Depends on bpc_pkg, bpc_in_if, bpc_out_if and bpc_step.
//
// Usage:
//   i_in carries one tick word per handshake: elapsed milliseconds and the four
//   button levels. o_out returns exactly one event word per tick word, in order:
//   event_valid/event_code report a classified press, backlight_kick flags that
//   a pressed button was seen (not while a debounce wait is still running).
//   The config port (i_cfg_we, i_cfg_idx, i_cfg_data) writes debounce, short and
//   long press times; index 3 is ignored. Write only while no tick is in flight.
//   A tick word passes from the input register through the phase update into
//   the output register. Throughput is one word per cycle while o_out.ready
//   stays high; the phase/countdown update is combinational logic between the
//   two registers, so consecutive ticks enter on consecutive clocks.
//   If the receiver stalls, the output register holds its word and the input
//   register holds one more; i_in.ready drops only when both are full.
//   Synchronous reset clears both stages, returns the tracker to idle with no
//   held button and a zero countdown, and restores the default press times.
module button_press_classifier
    import bpc_pkg::*;
#(
    parameter int DELAY_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bpc_in_if.sink               i_in,
    bpc_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0]      r_debounce_ms;
    logic [CFG_W-1:0]      r_short_ms;
    logic [CFG_W-1:0]      r_long_ms;

    logic                  r_s1_valid;
    t_tick                 r_s1;
    t_phase                r_phase;
    logic [CODE_W-1:0]     r_held;
    logic [DELAY_BITS-1:0] r_delay;
    logic                  r_out_valid;
    t_evt                  r_out;

    t_phase                n_phase;
    logic [CODE_W-1:0]     n_held;
    logic [DELAY_BITS-1:0] n_delay;
    t_evt                  n_out;

    logic                  out_free;
    logic                  s1_fire;
    logic                  in_fire;

    // Stage control
    assign out_free   = !r_out_valid || o_out.ready;
    assign s1_fire    = r_s1_valid && out_free;
    assign i_in.ready = !r_s1_valid || s1_fire;
    assign in_fire    = i_in.valid && i_in.ready;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms <= DEBOUNCE_RST;
            r_short_ms    <= SHORT_RST;
            r_long_ms     <= LONG_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEBOUNCE: r_debounce_ms <= i_cfg_data;
                CFG_SHORT:    r_short_ms    <= i_cfg_data;
                CFG_LONG:     r_long_ms     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1.elapsed_ms   <= i_in.elapsed_ms;
            r_s1.mode_level   <= i_in.mode_level;
            r_s1.left_level   <= i_in.left_level;
            r_s1.right_level  <= i_in.right_level;
            r_s1.toggle_level <= i_in.toggle_level;
        end
    end

    bpc_step #(
        .DELAY_BITS (DELAY_BITS)
    ) u_step (
        .i_tick        (r_s1),
        .i_phase       (r_phase),
        .i_held        (r_held),
        .i_delay       (r_delay),
        .i_debounce_ms (r_debounce_ms),
        .i_short_ms    (r_short_ms),
        .i_long_ms     (r_long_ms),
        .o_phase       (n_phase),
        .o_held        (n_held),
        .o_delay       (n_delay),
        .o_evt         (n_out)
    );

    // Tracker state advances once per tick word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= BTN_NONE;
            r_delay <= '0;
        end else if (s1_fire) begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_delay <= n_delay;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.event_valid    = r_out.event_valid;
    assign o_out.event_code     = r_out.event_code;
    assign o_out.backlight_kick = r_out.backlight_kick;

endmodule

// File: hdl/bpc_checker.sv
// Port-level checks for button_press_classifier, attached by bind.
// Depends on bpc_pkg and the top level's ports.
module bpc_checker
    import bpc_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic              i_event_valid,
    input logic [CODE_W-1:0] i_event_code,
    input logic              i_backlight_kick
);

    // Event codes stay within mode..mode-hold
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_event_valid) |-> (i_event_code <= BTN_HOLD))
        else $error("event code out of range");

    // No event means a zero code
    a_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_event_valid) |-> (i_event_code == BTN_MODE))
        else $error("nonzero code without event");

    // A stalled word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_event_valid) && $stable(i_event_code)
             && $stable(i_backlight_kick)))
        else $error("output word changed under stall");

    // Every accepted tick passes the input register into the output register (or the earlier word still waits)
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((i_in_valid && i_in_ready) ##1 i_rst_n) |=> i_out_valid)
        else $error("accepted tick produced no output");

    // With the output empty the input side always accepts
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked while output empty");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_event_valid    (o_out.event_valid),
    .i_event_code     (o_out.event_code),
    .i_backlight_kick (o_out.backlight_kick)
);

// File: test/tb_button_press_classifier.sv
// Self-checking testbench for button_press_classifier: tick words in, one event word out each.
// Depends on bpc_pkg, bpc_in_if, bpc_out_if and the block itself.
// A local press tracker predicts every event word; results are checked in order.
module tb_button_press_classifier
    import bpc_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DELAY_BITS      = 16;
    localparam int DELAY_MAX       = (1 << (DELAY_BITS - 1)) - 1;
    localparam int DELAY_MIN       = -DELAY_MAX - 1;
    localparam int PRESSURE_CYCLES = 300;
    localparam int STALL_LIMIT     = 2000;
    localparam int SETTING_COUNT   = 8;
    localparam int TICKS_PER_SET   = 190;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic i_clk;
    logic i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    bpc_in_if  tick_if ();
    bpc_out_if evt_if ();

    button_press_classifier #(
        .DELAY_BITS(DELAY_BITS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (tick_if),
        .o_out      (evt_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Press tracker mirror and its timing registers
    t_phase            trk_phase;
    logic [CODE_W-1:0] trk_held;
    int                trk_delay;
    logic [CFG_W-1:0]  debounce_set;
    logic [CFG_W-1:0]  short_set;
    logic [CFG_W-1:0]  long_set;

    t_tick tick_queue[$];
    t_evt  evt_expected[$];
    t_tick tick_on_bus;

    int  send_wait;
    int  recv_wait;
    int  recv_draw;
    bit  send_calm;
    bit  recv_calm;
    int  quiet_cycles;
    int  ticks_accepted;
    int  results_seen;
    int  events_seen;
    int  holds_seen;
    int  fail_count;
    t_evt evt_got;
    t_evt evt_want;

    function automatic int clamp_delay(int v);
        if (v > DELAY_MAX) return DELAY_MAX;
        if (v < DELAY_MIN) return DELAY_MIN;
        return v;
    endfunction

    // Wait-short test: shared by the short phase and a debounce that just expired
    function automatic t_evt short_check(logic [CODE_W-1:0] btn);
        t_evt r;
        r = '0;
        r.backlight_kick = (btn != BTN_NONE);
        if (btn != trk_held) begin
            r.event_valid = 1'b1;
            r.event_code  = trk_held;
            trk_phase     = PH_RELEASE;
        end else if (trk_delay <= 0) begin
            if (trk_held == BTN_MODE) begin
                trk_phase = PH_LONG;
                trk_delay = clamp_delay(int'(long_set) - int'(short_set));
            end else begin
                r.event_valid = 1'b1;
                r.event_code  = trk_held;
                trk_phase     = PH_RELEASE;
            end
        end
        return r;
    endfunction

    // One tick of the press tracker: returns the event word it produces
    function automatic t_evt predict_event(t_tick t);
        logic [CODE_W-1:0] btn;
        int   e;
        t_evt r;
        btn = t.mode_level   ? BTN_MODE   :
              t.left_level   ? BTN_LEFT   :
              t.right_level  ? BTN_RIGHT  :
              t.toggle_level ? BTN_TOGGLE : BTN_NONE;
        e = int'(t.elapsed_ms);
        r = '0;
        case (trk_phase)
            PH_DEBOUNCE: begin
                trk_delay = clamp_delay(trk_delay - e);
                // levels are ignored until the debounce time is used up
                if (trk_delay <= 0) begin
                    trk_delay = clamp_delay(int'(short_set));
                    trk_phase = PH_SHORT;
                    r = short_check(btn);
                end
            end
            PH_SHORT: begin
                trk_delay = clamp_delay(trk_delay - e);
                r = short_check(btn);
            end
            PH_LONG: begin
                trk_delay = clamp_delay(trk_delay - e);
                r.backlight_kick = (btn != BTN_NONE);
                if (btn != trk_held) begin
                    // mode let go early: plain mode event, then straight back to idle
                    r.event_valid = 1'b1;
                    r.event_code  = trk_held;
                    trk_held      = BTN_NONE;
                    trk_phase     = PH_IDLE;
                end else if (trk_delay <= 0) begin
                    r.event_valid = 1'b1;
                    r.event_code  = BTN_HOLD;
                    trk_phase     = PH_RELEASE;
                end
            end
            PH_RELEASE: begin
                r.backlight_kick = (btn != BTN_NONE);
                if (btn != trk_held) begin
                    trk_held  = BTN_NONE;
                    trk_phase = PH_IDLE;
                end
            end
            default: begin
                r.backlight_kick = (btn != BTN_NONE);
                trk_held = btn;
                if (btn != BTN_NONE) begin
                    trk_delay = clamp_delay(int'(debounce_set));
                    trk_phase = PH_DEBOUNCE;
                end
            end
        endcase
        return r;
    endfunction

    // Idle gap before the next word: none in calm stretches, else none or a random gap
    function automatic int draw_wait(bit calm);
        if (calm || $urandom_range(0, 1) == 0) return 0;
        return $urandom_range(1, 17);
    endfunction

    // lv is {mode, left, right, toggle}
    function automatic void queue_tick(int e, logic [3:0] lv);
        t_tick t;
        t.elapsed_ms   = ELAPSED_W'(e);
        t.mode_level   = lv[3];
        t.left_level   = lv[2];
        t.right_level  = lv[1];
        t.toggle_level = lv[0];
        tick_queue.push_back(t);
    endfunction

    // Mostly press/hold/release sequences, some noise and broken holds
    task automatic queue_random(int n);
        int count;
        int hold;
        int rel;
        int emax;
        int b;
        int k;
        logic [3:0] own;
        logic [3:0] lv;
        count = 0;
        while (count < n) begin
            if ($urandom_range(0, 9) < 7) begin
                b   = $urandom_range(0, 3);
                own = 4'b1000 >> b;
                case ($urandom_range(0, 2))
                    0: emax = 15;
                    1: emax = 127;
                    default: emax = 1023;
                endcase
                hold = $urandom_range(1, 30);
                for (k = 0; k < hold; k++) begin
                    // lower-priority buttons may chatter without changing the winner
                    lv = own | (4'($urandom()) & (own - 4'd1));
                    if ($urandom_range(0, 15) == 0) lv = 4'($urandom());
                    queue_tick($urandom_range(0, emax), lv);
                    count++;
                end
                rel = $urandom_range(1, 4);
                for (k = 0; k < rel; k++) begin
                    queue_tick($urandom_range(0, emax), 4'b0000);
                    count++;
                end
            end else begin
                rel = $urandom_range(1, 10);
                for (k = 0; k < rel; k++) begin
                    queue_tick($urandom_range(0, 1023), 4'($urandom()));
                    count++;
                end
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            CFG_DEBOUNCE: debounce_set = val;
            CFG_SHORT:    short_set    = val;
            CFG_LONG:     long_set     = val;
            default: ;
        endcase
    endtask

    // Block is idle once nothing is queued, offered or awaited
    task automatic wait_idle();
        @(negedge i_clk);
        while (tick_queue.size() != 0 || tick_if.valid || evt_expected.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Tick driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tick_if.valid <= 1'b0;
            send_wait     <= 0;
        end else begin
            if (tick_if.valid && tick_if.ready) begin
                evt_expected.push_back(predict_event(tick_on_bus));
                ticks_accepted++;
            end
            if (!tick_if.valid || tick_if.ready) begin
                if (send_wait != 0) begin
                    send_wait     <= send_wait - 1;
                    tick_if.valid <= 1'b0;
                end else if (tick_queue.size() != 0) begin
                    tick_on_bus = tick_queue.pop_front();
                    if ($urandom_range(0, 47) == 0) send_calm = !send_calm;
                    tick_if.valid        <= 1'b1;
                    tick_if.elapsed_ms   <= tick_on_bus.elapsed_ms;
                    tick_if.mode_level   <= tick_on_bus.mode_level;
                    tick_if.left_level   <= tick_on_bus.left_level;
                    tick_if.right_level  <= tick_on_bus.right_level;
                    tick_if.toggle_level <= tick_on_bus.toggle_level;
                    send_wait            <= draw_wait(send_calm);
                end else begin
                    tick_if.valid <= 1'b0;
                end
            end
        end
    end

    // Event monitor and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            evt_if.ready <= 1'b0;
            recv_wait    <= 0;
        end else if (evt_if.valid && evt_if.ready) begin
            evt_got.event_valid    = evt_if.event_valid;
            evt_got.event_code     = evt_if.event_code;
            evt_got.backlight_kick = evt_if.backlight_kick;
            if (evt_expected.size() == 0) begin
                $display("%0t: event word with nothing expected: valid %0b code %0d kick %0b",
                         $time, evt_got.event_valid, evt_got.event_code,
                         evt_got.backlight_kick);
                fail_count++;
            end else begin
                evt_want = evt_expected.pop_front();
                if (evt_got.event_valid !== evt_want.event_valid) begin
                    $display("%0t: event_valid expected %0b, got %0b",
                             $time, evt_want.event_valid, evt_got.event_valid);
                    fail_count++;
                end
                if (evt_got.event_code !== evt_want.event_code) begin
                    $display("%0t: event_code expected %0d, got %0d",
                             $time, evt_want.event_code, evt_got.event_code);
                    fail_count++;
                end
                if (evt_got.backlight_kick !== evt_want.backlight_kick) begin
                    $display("%0t: backlight_kick expected %0b, got %0b",
                             $time, evt_want.backlight_kick, evt_got.backlight_kick);
                    fail_count++;
                end
            end
            results_seen++;
            if (evt_got.event_valid === 1'b1) events_seen++;
            if (evt_got.event_valid === 1'b1 && evt_got.event_code === BTN_HOLD) holds_seen++;
            if ($urandom_range(0, 47) == 0) recv_calm = !recv_calm;
            if (results_seen % 500 == 250) begin
                // long hold-off so both stages fill and the input stalls
                evt_if.ready <= 1'b0;
                recv_wait    <= PRESSURE_CYCLES;
            end else begin
                recv_draw     = draw_wait(recv_calm);
                evt_if.ready <= (recv_draw == 0);
                recv_wait    <= recv_draw;
            end
        end else if (recv_wait != 0) begin
            recv_wait    <= recv_wait - 1;
            evt_if.ready <= (recv_wait == 1);
        end else begin
            evt_if.ready <= 1'b1;
        end
    end

    // Watchdog on handshake activity
    always @(posedge i_clk) begin
        if (!i_rst_n || (tick_if.valid && tick_if.ready) || (evt_if.valid && evt_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("[button_press_classifier] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus: reset, directed ticks, then random ticks over several timing settings
    initial begin
        logic [CFG_W-1:0] set_deb  [SETTING_COUNT];
        logic [CFG_W-1:0] set_short[SETTING_COUNT];
        logic [CFG_W-1:0] set_long [SETTING_COUNT];
        int p;

        tick_if.valid        = 1'b0;
        tick_if.elapsed_ms   = '0;
        tick_if.mode_level   = 1'b0;
        tick_if.left_level   = 1'b0;
        tick_if.right_level  = 1'b0;
        tick_if.toggle_level = 1'b0;
        evt_if.ready         = 1'b0;
        cfg_we               = 1'b0;
        cfg_idx              = CFG_DEBOUNCE;
        cfg_data             = '0;
        i_rst_n              = 1'b0;
        trk_phase            = PH_IDLE;
        trk_held             = BTN_NONE;
        trk_delay            = 0;
        debounce_set         = DEBOUNCE_RST;
        short_set            = SHORT_RST;
        long_set             = LONG_RST;
        send_calm            = 1'b0;
        recv_calm            = 1'b0;
        ticks_accepted       = 0;
        results_seen         = 0;
        events_seen          = 0;
        holds_seen           = 0;
        fail_count           = 0;

        // entry 0 is the reset setting; then minimum, maximum, zero, long below short, maximum long, then random
        set_deb[1] = 14'd1;     set_short[1] = 14'd1;     set_long[1] = 14'd1;
        set_deb[2] = 14'd16383; set_short[2] = 14'd16383; set_long[2] = 14'd16383;
        set_deb[3] = 14'd0;     set_short[3] = 14'd0;     set_long[3] = 14'd0;
        set_deb[4] = 14'd10;    set_short[4] = 14'd100;   set_long[4] = 14'd50;
        set_deb[5] = 14'd5;     set_short[5] = 14'd20;    set_long[5] = 14'd16383;
        for (p = 6; p < SETTING_COUNT; p++) begin
            set_deb[p]   = CFG_W'($urandom_range(1, 100));
            set_short[p] = CFG_W'($urandom_range(1, 400));
            set_long[p]  = CFG_W'($urandom_range(1, 3000));
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // mode held to the hold time with all buttons down at the start, full elapsed
        queue_tick(0, 4'b0000);
        queue_tick(1023, 4'b1111);
        queue_tick(1023, 4'b1111);
        queue_tick(1023, 4'b1000);
        queue_tick(1023, 4'b1000);
        queue_tick(1023, 4'b1000);
        queue_tick(0, 4'b0000);
        // left released before the short time
        queue_tick(0, 4'b0100);
        queue_tick(10, 4'b0100);
        queue_tick(10, 4'b0100);
        queue_tick(5, 4'b0000);
        queue_tick(0, 4'b0000);
        // right held to the short time
        queue_tick(0, 4'b0011);
        queue_tick(25, 4'b0011);
        queue_tick(25, 4'b0011);
        queue_tick(50, 4'b0010);
        queue_tick(7, 4'b0000);
        // toggle replaced by left before the short time
        queue_tick(0, 4'b0001);
        queue_tick(30, 4'b0001);
        queue_tick(1, 4'b0100);
        queue_tick(0, 4'b0100);
        queue_tick(0, 4'b0000);
        // mode let go between the short and the long time
        queue_tick(0, 4'b1000);
        queue_tick(20, 4'b1000);
        queue_tick(60, 4'b1000);
        queue_tick(100, 4'b0000);

        for (p = 0; p < SETTING_COUNT; p++) begin
            if (p != 0) begin
                wait_idle();
                write_reg(CFG_DEBOUNCE, set_deb[p]);
                write_reg(CFG_SHORT, set_short[p]);
                write_reg(CFG_LONG, set_long[p]);
                write_reg(CFG_UNUSED, CFG_W'($urandom()));
                @(posedge i_clk);
                cfg_we <= 1'b0;
            end
            queue_random(TICKS_PER_SET);
        end

        wait_idle();
        repeat (8) @(posedge i_clk);

        $display("Covered %0d ticks over %0d timing settings: %0d button events, %0d mode-hold.",
                 ticks_accepted, SETTING_COUNT, events_seen, holds_seen);
        $display("Checked %0d event words, %0d mismatches.", results_seen, fail_count);
        if (fail_count == 0 && evt_expected.size() == 0) begin
            $display("[button_press_classifier] OK");
        end else begin
            $display("[button_press_classifier] ERROR");
        end
        $finish;
    end

endmodule
